// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLKED(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) `ASSERT_CLKED(lbl, !(cond))
`else
`define ASSERT_CLKED(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/mrs_pkg.sv =====
// ---------------------------------------------------------------------------
// mrs_pkg
// Types and constants of the row-streaming matrix multiply unit.
// ---------------------------------------------------------------------------
package mrs_pkg;

  localparam int MAX_INNER = 16;
  localparam int MAX_COLS  = 64;

  localparam int VALUE_W = 16;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int SUM_W   = 36;
  localparam int POS_W   = 4;
  localparam int INNER_W = 5;
  localparam int COLS_W  = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [INNER_W-1:0] INNER_RST = INNER_W'(5);
  localparam logic [COLS_W-1:0]  COLS_RST  = COLS_W'(64);

  typedef enum logic {
    CMD_LOAD_B = 1'b0,
    CMD_A_ELEM = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_INNER_SIZE = 1'b0,
    REG_COL_COUNT  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e               command;
    logic [ROW_W-1:0]   b_row;
    logic [COL_W-1:0]   b_col;
    logic [VALUE_W-1:0] elem_value;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] col_index;
    logic [SUM_W-1:0] product_sum;
    logic             last;
  } out_beat_t;

endpackage

// ===== rtl/mrs_ram.sv =====
// ---------------------------------------------------------------------------
// mrs_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module mrs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mrs_cell.sv =====
// ---------------------------------------------------------------------------
// mrs_cell
// One column sum of the rotating accumulator ring.
// ---------------------------------------------------------------------------
module mrs_cell #(
  parameter int Width = mrs_pkg::SUM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [Width-1:0] sum_i,
  output logic [Width-1:0] sum_o
);

  logic [Width-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = shift_i ? sum_i : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/matrix_multiply_row_stream_unit.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply_row_stream_unit
// Row-streaming X = A * B: B held in a RAM, one sum cell per result column.
// ---------------------------------------------------------------------------
// A B load (command 0) leaves busy low. An A element (command 1) holds busy
// while the B row is read one column a cycle through the single RAM port
// and each product is added into the sum at the head of a ring of MaxCols
// cells that rotates one place per column. On the final element of a row
// the results leave one per cycle, in column order, on res_valid_o and res_o,
// and the receiver cannot stall them; last marks the final column. Write the
// registers only while busy is low.
module matrix_multiply_row_stream_unit #(
  parameter int MaxInner = mrs_pkg::MAX_INNER,
  parameter int MaxCols  = mrs_pkg::MAX_COLS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  mrs_pkg::in_beat_t                cmd_i,
  output logic                             res_valid_o,
  output mrs_pkg::out_beat_t               res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrs_pkg::APB_AW-1:0]       paddr,
  input  logic [mrs_pkg::APB_DW-1:0]       pwdata,
  output logic [mrs_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int Depth = MaxInner * MaxCols;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // configuration
  logic [mrs_pkg::INNER_W-1:0] inner_size_q;
  logic [mrs_pkg::COLS_W-1:0]  col_count_q;
  logic                        cfg_wr;
  mrs_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = mrs_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_size_q <= mrs_pkg::INNER_RST;
      col_count_q  <= mrs_pkg::COLS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mrs_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[mrs_pkg::INNER_W-1:0];
        mrs_pkg::REG_COL_COUNT:  col_count_q  <= pwdata[mrs_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mrs_pkg::REG_INNER_SIZE: prdata = mrs_pkg::APB_DW'(inner_size_q);
      mrs_pkg::REG_COL_COUNT:  prdata = mrs_pkg::APB_DW'(col_count_q);
      default:                 prdata = '0;
    endcase
  end

  // effective sizes
  logic [mrs_pkg::INNER_W-1:0] n_inner;
  logic [mrs_pkg::COLS_W-1:0]  n_cols;

  always_comb begin
    if (inner_size_q == '0) begin
      n_inner = mrs_pkg::INNER_W'(1);
    end else if (int'(inner_size_q) > MaxInner) begin
      n_inner = mrs_pkg::INNER_W'(MaxInner);
    end else begin
      n_inner = inner_size_q;
    end
    if (col_count_q == '0) begin
      n_cols = mrs_pkg::COLS_W'(1);
    end else if (int'(col_count_q) > MaxCols) begin
      n_cols = mrs_pkg::COLS_W'(MaxCols);
    end else begin
      n_cols = col_count_q;
    end
  end

  // accept
  logic accept, acc_a, acc_b, b_in_range;

  assign accept     = start && !busy;
  assign acc_a      = accept && (cmd_i.command == mrs_pkg::CMD_A_ELEM);
  assign acc_b      = accept && (cmd_i.command == mrs_pkg::CMD_LOAD_B);
  assign b_in_range = (int'(cmd_i.b_row) < MaxInner) && (int'(cmd_i.b_col) < MaxCols);

  // row position and per-beat context
  logic [mrs_pkg::POS_W-1:0]   inner_pos_q, inner_pos_d;
  logic                        fin_q, fin_d;
  logic [mrs_pkg::VALUE_W-1:0] val_q;
  logic [AddrW-1:0]            base_q;
  logic [AddrW-1:0]            row_k;

  always_comb begin
    fin_d       = ({1'b0, inner_pos_q} + mrs_pkg::INNER_W'(1)) >= n_inner;
    inner_pos_d = fin_d ? '0 : inner_pos_q + mrs_pkg::POS_W'(1);
    if (int'(inner_pos_q) >= MaxInner) begin
      row_k = AddrW'(MaxInner - 1);
    end else begin
      row_k = AddrW'(inner_pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_pos_q <= '0;
      fin_q       <= 1'b0;
    end else if (acc_a) begin
      inner_pos_q <= inner_pos_d;
      fin_q       <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_a) begin
      val_q  <= cmd_i.elem_value;
      base_q <= AddrW'(row_k * AddrW'(MaxCols));
    end
  end

  // column sequencer: issue, RAM read, multiply
  logic            run_q, b_vld_q, p_vld_q;
  logic [ColW-1:0] iss_q, b_col_q, p_col_q;
  logic [mrs_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      iss_q   <= '0;
      b_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else begin
      if (acc_a) begin
        run_q <= 1'b1;
        iss_q <= '0;
      end else if (run_q) begin
        if (int'(iss_q) == MaxCols - 1) begin
          run_q <= 1'b0;
          iss_q <= '0;
        end else begin
          iss_q <= iss_q + ColW'(1);
        end
      end
      b_vld_q <= run_q;
      p_vld_q <= b_vld_q;
    end
  end

  logic [AddrW-1:0]            ram_addr, ld_addr;
  logic [mrs_pkg::VALUE_W-1:0] b_elem;

  assign ld_addr  = AddrW'(AddrW'(cmd_i.b_row) * AddrW'(MaxCols)) + AddrW'(cmd_i.b_col);
  assign ram_addr = run_q ? base_q + AddrW'(iss_q) : ld_addr;

  mrs_ram #(
    .Width (mrs_pkg::VALUE_W),
    .Depth (Depth)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (acc_b && b_in_range),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.elem_value),
    .rdata_o (b_elem)
  );

  always_ff @(posedge clk_i) begin
    b_col_q <= iss_q;
    p_col_q <= b_col_q;
    prod_q  <= mrs_pkg::PROD_W'(val_q) * mrs_pkg::PROD_W'(b_elem);
  end

  // sum ring
  logic [mrs_pkg::SUM_W-1:0] ring [MaxCols];
  logic [mrs_pkg::SUM_W-1:0] sum_new, ring_in;
  logic                      in_cols;

  always_comb begin
    in_cols = mrs_pkg::COLS_W'(p_col_q) < n_cols;
    sum_new = in_cols ? ring[0] + mrs_pkg::SUM_W'(prod_q) : ring[0];
    ring_in = fin_q ? '0 : sum_new;
  end

  for (genvar i = 0; i < MaxCols; i++) begin : g_cell
    logic [mrs_pkg::SUM_W-1:0] nxt;
    if (i == MaxCols - 1) begin : g_tail
      assign nxt = ring_in;
    end else begin : g_link
      assign nxt = ring[i+1];
    end
    mrs_cell #(
      .Width (mrs_pkg::SUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (p_vld_q),
      .sum_i   (nxt),
      .sum_o   (ring[i])
    );
  end

  // result beat
  logic               out_vld_q;
  mrs_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p_vld_q && fin_q && in_cols;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.col_index   <= mrs_pkg::COL_W'(p_col_q);
    out_q.product_sum <= sum_new;
    out_q.last        <= (mrs_pkg::COLS_W'(p_col_q) + mrs_pkg::COLS_W'(1)) == n_cols;
  end

  assign busy        = run_q || b_vld_q || p_vld_q;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

`include "assert_macros.svh"

  `ASSERT_CLKED(a_res_in_pass, res_valid_o |-> $past(busy))
  `ASSERT_CLKED(a_last_ends_row, res_valid_o && res_o.last |=> !res_valid_o)
  `ASSERT_CLKED(a_elem_starts_pass, acc_a |=> busy)
  `ASSERT_CLKED(a_load_no_pass, acc_b |=> !busy)
  `ASSERT_NEVER(a_pos_range, int'(inner_pos_q) >= MaxInner)

endmodule

// ===== dv/matrix_multiply_row_stream_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_multiply_row_stream_unit_tb
// Drives B loads and A rows into the row-streaming multiplier and checks
// every result beat against an in-bench predictor of X = A * B. Register
// writes go through the APB port between phases and are read back.
// ---------------------------------------------------------------------------
module matrix_multiply_row_stream_unit_tb;
  import mrs_pkg::*;

  localparam int          SETTLE_CYCLES = 80;    // A element occupancy plus margin
  localparam int          DRAIN_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          PHASE_ITEMS   = 56;
  localparam int          SHAPE_ITEMS   = 14;

  class row_product_tracker;
    bit [VALUE_W-1:0] b_mem [MAX_INNER][MAX_COLS];
    bit [SUM_W:0]     col_acc [MAX_COLS];
    bit [POS_W-1:0]   pos;
    bit [INNER_W-1:0] inner_reg;
    bit [COLS_W-1:0]  cols_reg;
    out_beat_t        row_q[$];
    int unsigned      errors;

    function new();
      pos       = '0;
      inner_reg = INNER_RST;
      cols_reg  = COLS_RST;
      errors    = 0;
      foreach (col_acc[c]) col_acc[c] = '0;
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DW-1:0] val);
      case (idx)
        REG_INNER_SIZE: inner_reg = val[INNER_W-1:0];
        REG_COL_COUNT:  cols_reg  = val[COLS_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted beat: B load or next A element of the current row
    function void note_beat(in_beat_t beat);
      int        n_inner;
      int        n_cols;
      out_beat_t r;
      n_inner = (inner_reg == 0) ? 1 : (inner_reg > MAX_INNER) ? MAX_INNER : int'(inner_reg);
      n_cols  = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
      if (beat.command == CMD_LOAD_B) begin
        b_mem[beat.b_row][beat.b_col] = beat.elem_value;
        return;
      end
      for (int c = 0; c < n_cols; c++) begin
        col_acc[c] = col_acc[c] + beat.elem_value * b_mem[pos][c];
      end
      if (int'(pos) + 1 < n_inner) begin
        pos++;
        return;
      end
      for (int c = 0; c < n_cols; c++) begin
        r.col_index   = COL_W'(c);
        r.product_sum = col_acc[c][SUM_W-1:0];
        r.last        = (c == n_cols - 1);
        row_q.push_back(r);
      end
      foreach (col_acc[c]) col_acc[c] = '0;
      pos = '0;
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (row_q.size() == 0) begin
        flag($sformatf("unexpected beat col %0d sum %h last %b",
                       got.col_index, got.product_sum, got.last));
        return;
      end
      want = row_q.pop_front();
      if (got.col_index !== want.col_index || got.product_sum !== want.product_sum ||
          got.last !== want.last) begin
        flag($sformatf("expected col %0d sum %h last %b, got col %0d sum %h last %b",
                       want.col_index, want.product_sum, want.last,
                       got.col_index, got.product_sum, got.last));
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  in_beat_t           cmd_i;
  logic               res_valid_o;
  out_beat_t          res_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  row_product_tracker tracker = new();
  int unsigned        idle_pct;
  int unsigned        cycles = 0;

  matrix_multiply_row_stream_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) tracker.check_beat(res_o);
      if (start && !busy) tracker.note_beat(cmd_i);
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // widest column count loaded for every B row up to row_hi
  function automatic int unsigned col_cap(int unsigned row_hi);
    if (row_hi < 2) return MAX_COLS;
    if (row_hi < 4) return MAX_COLS / 2;
    return 8;
  endfunction

  // start stays high across back-to-back beats
  task automatic send(in_beat_t beat);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_load(int unsigned row, int unsigned col, logic [VALUE_W-1:0] val);
    in_beat_t beat;
    beat.command    = CMD_LOAD_B;
    beat.b_row      = ROW_W'(row);
    beat.b_col      = COL_W'(col);
    beat.elem_value = val;
    send(beat);
  endtask

  task automatic send_elem(logic [VALUE_W-1:0] val);
    in_beat_t beat;
    beat.command    = CMD_A_ELEM;
    beat.b_row      = ROW_W'($urandom);
    beat.b_col      = COL_W'($urandom);
    beat.elem_value = val;
    send(beat);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.row_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] want_val;
    want_val = (idx == REG_INNER_SIZE) ? val & 32'h1f : val & 32'h7f;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want_val) begin
      tracker.flag($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want_val));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(int unsigned inner, int unsigned ncols);
    reg_write(REG_INNER_SIZE, inner);
    reg_write(REG_COL_COUNT, ncols);
  endtask

  initial begin
    int unsigned inner;
    int unsigned ncols;
    int unsigned eff_inner;
    int unsigned row_hi;
    int unsigned cap;
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd_i    = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 15;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // each B row loaded as wide as col_cap allows; every shape stays inside it
    set_shape(16, col_cap(MAX_INNER - 1));
    for (int r = 0; r < MAX_INNER; r++) begin
      for (int c = 0; c < int'(col_cap(r)); c++) send_load(r, c, '1);
    end
    repeat (16) send_elem('1);

    quiesce();
    set_shape(1, 1);
    send_load(0, 0, '0);
    send_elem('1);
    send_load(0, 0, 16'h8000);
    send_elem('1);
    send_elem('0);
    send_load(15, 63, 16'h0001);

    // zero registers behave as one
    quiesce();
    set_shape(0, 0);
    send_elem(16'h1234);

    // oversize registers clamp, then a shape change part way through a row
    quiesce();
    set_shape(31, 127);
    send_elem(pick_value());
    send_elem(pick_value());
    quiesce();
    set_shape(2, 2);
    send_elem(pick_value());

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 15 : (ph == 1) ? 67 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SHAPE_ITEMS == 0) begin
          quiesce();
          inner = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 31);
          eff_inner = (inner == 0) ? 1 : (inner > MAX_INNER) ? MAX_INNER : inner;
          row_hi = eff_inner - 1;
          if (tracker.pos > row_hi) row_hi = tracker.pos;
          cap = col_cap(row_hi);
          ncols = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, cap);
          if (ncols > cap && cap < MAX_COLS) ncols = $urandom_range(0, cap);
          set_shape(inner, ncols);
        end
        if ($urandom_range(99) < 80) send_elem(pick_value());
        else send_load($urandom_range(15), $urandom_range(63), pick_value());
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.row_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.row_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
